>>> hw/rtl/bss_pkg.sv
// bss_pkg: shared types, constants and helper functions of the bounded string scanner
// used by the channel interfaces, the window cells, the result queue and the top level
package bss_pkg;

	// sizing
	localparam int MAX_PATTERN  = 16;
	localparam int OFFSET_BITS  = 32;
	localparam int PAT_BYTES    = 16;
	localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
	localparam int PLEN_W       = 5;
	localparam int OFF_W        = 32;
	localparam int CNT_W        = 32;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 2;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	// printable range
	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd126;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2,
		REG_EXACT_MODE     = 2'd3
	} cfg_reg_t;

	// control shared by every window cell
	typedef struct packed {
		logic shift;
		logic exact;
	} cell_ctrl_t;

	// one result entry
	typedef struct packed {
		logic [OFF_W-1:0] match_offset;
		logic [CNT_W-1:0] match_number;
		logic             last;
	} result_t;

	// upper-case fold of ascii letters
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7a) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	function automatic logic printable(input logic [7:0] c);
		return (c >= PRINT_LO) && (c <= PRINT_HI);
	endfunction

	// pattern byte i of the 128-bit pattern, zero beyond the stored bytes
	function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
			input logic [IDX_W-1:0] i);
		logic [7:0] r;
		r = 8'h00;
		for (int k = 0; k < PAT_BYTES; k++) begin
			if (int'(i) == k) begin
				r = pat[8*k +: 8];
			end
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/bss_ifs.sv
// bss_ifs: valid/ready channel interfaces of the bounded string scanner
// depends on bss_pkg for field widths

// input byte channel
interface bss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       region_end;

	modport source (output valid, output data_byte, output region_end, input ready);
	modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

// match result channel
interface bss_out_if;
	import bss_pkg::*;
	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] match_offset;
	logic [CNT_W-1:0] match_number;
	logic             last;

	modport source (output valid, output match_offset, output match_number, output last,
		input ready);
	modport sink (input valid, input match_offset, input match_number, input last,
		output ready);
endinterface

>>> hw/rtl/bss_cell.sv
// bss_cell: one byte of the scan window, shifted on from its neighbor each accepted byte
// compares its incoming byte against the aligned pattern byte; depends on bss_pkg
module bss_cell
	import bss_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       active,
	input  logic [7:0] byte_in,
	input  logic [7:0] pattern_byte,
	output logic [7:0] stored_byte,
	output logic       eq
);

	logic [7:0] byte_q;

	// window byte, handed to the next cell
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	assign stored_byte = byte_q;

	// compare the byte entering this slot; unused slots always agree
	always_comb begin
		if (!active) begin
			eq = 1'b1;
		end else if (ctrl.exact) begin
			eq = (byte_in == pattern_byte);
		end else begin
			eq = (fold(byte_in) == fold(pattern_byte));
		end
	end

endmodule

>>> hw/rtl/bss_out_queue.sv
// bss_out_queue: small result queue taking up to two entries per cycle, one out per cycle
// depends on bss_pkg for result_t and queue sizing
module bss_out_queue
	import bss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push0,
	input  logic    push1,
	input  result_t entry0,
	input  result_t entry1,
	input  logic    pop,
	output result_t head,
	output logic    not_empty,
	output logic    room2
);

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_ptr_p1;
	logic [QCNT_W-1:0] n_push;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign n_push    = QCNT_W'(push0) + QCNT_W'(push1);

	// storage
	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= entry0;
		end
		if (push1) begin
			mem_q[wr_ptr_p1] <= entry1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - QCNT_W'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= QCNT_W'(QDEPTH - 2));

endmodule

>>> hw/rtl/bounded_string_scanner.sv
// bounded_string_scanner: top level, pattern registers, row of window cells and hit tracking
// depends on bss_pkg, bss_ifs, bss_cell and bss_out_queue
//
//   channel  dir  handshake     payload
//   scan     in   valid/ready   data_byte[7:0], region_end
//   hits     out  valid/ready   match_offset[31:0], match_number[31:0], last
//   cfg      in   cfg_we        cfg_index[1:0], cfg_data[63:0]
//
// one byte per cycle while scan.ready holds; the window compare and hit decision finish in the accept cycle
// results go through a four-entry queue and leave one per cycle while hits.ready holds, the first one the cycle after
// scan.ready drops while fewer than two queue entries are free (hits stalled)
// reset clears the region state and sets pattern_length to one; region_end clears it again
module bounded_string_scanner
	import bss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	bss_in_if.sink               scan,
	bss_out_if.source            hits,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [CNT_W-1:0]       CNT_MAX = '1;

	// configuration registers
	logic [63:0]       pattern_low_q;
	logic [63:0]       pattern_high_q;
	logic [PLEN_W-1:0] pattern_length_q;
	logic              exact_mode_q;

	// region state
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] resume_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   pend_q;
	logic [OFFSET_BITS-1:0] pend_off_q;

	logic                   accept;
	logic [LEN_W-1:0]       len_c;
	logic [LEN_W-1:0]       len_m1;
	logic [8*PAT_BYTES-1:0] pattern;
	cell_ctrl_t             ctrl;
	logic [7:0]             win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;
	logic [7:0]             lead_byte;
	logic [OFFSET_BITS-1:0] start;
	logic                   hit;
	logic                   acc_new;
	logic                   rel;
	logic                   emit_new;
	logic [CNT_W-1:0]       cnt1;
	logic [CNT_W-1:0]       cnt2;
	logic                   push0;
	logic                   push1;
	result_t                entry0;
	result_t                entry1;
	result_t                head;
	logic                   not_empty;
	logic                   room2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= PLEN_W'(1);
			exact_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data[63:0];
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data[63:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[PLEN_W-1:0];
				REG_EXACT_MODE:     exact_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept  = scan.valid && scan.ready;
	assign pattern = {pattern_high_q, pattern_low_q};
	assign len_c   = (pattern_length_q > PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
		: LEN_W'(pattern_length_q);
	assign len_m1  = len_c - 1'b1;
	assign ctrl    = '{shift: accept, exact: exact_mode_q};

	// row of window cells; cell k sees the byte k places back, aligned to pattern byte len-1-k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [7:0]       byte_in;
		logic [IDX_W-1:0] pidx;
		logic             active;

		if (k == 0) begin : g_head
			assign byte_in = scan.data_byte;
		end else begin : g_link
			assign byte_in = win[k-1];
		end
		assign pidx   = IDX_W'(int'(len_m1) - k);
		assign active = (len_c > LEN_W'(k));

		bss_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.active       (active),
			.byte_in      (byte_in),
			.pattern_byte (pat_byte(pattern, pidx)),
			.stored_byte  (win[k]),
			.eq           (eq[k])
		);
	end

	// byte just before the candidate
	assign lead_byte = win[IDX_W'(len_m1)];

	// hit decision for the candidate ending at this byte
	assign start = pos_q - OFFSET_BITS'(len_m1);
	always_comb begin
		hit = (len_c != '0) && (pos_q != OFF_MAX) && (pos_q >= OFFSET_BITS'(len_m1))
			&& (start >= resume_q) && (&eq);
	end
	assign acc_new  = hit && ((start == '0) || !printable(lead_byte));
	assign rel      = pend_q && !printable(scan.data_byte);
	assign emit_new = acc_new && scan.region_end;

	// saturating running counts
	assign cnt1 = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt2 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + 1'b1;

	// results of this byte: released pending hit first, then a hit closed by region end
	always_comb begin
		entry0 = '{match_offset: OFF_W'(start), match_number: cnt1, last: 1'b1};
		entry1 = '{match_offset: OFF_W'(start), match_number: cnt2, last: 1'b1};
		if (rel) begin
			entry0.match_offset = OFF_W'(pend_off_q);
			entry0.last         = !emit_new;
		end
		push0 = accept && (rel || emit_new);
		push1 = accept && rel && emit_new;
	end

	// region state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			resume_q <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
		end else if (accept) begin
			if (scan.region_end) begin
				pos_q    <= '0;
				resume_q <= '0;
				cnt_q    <= '0;
				pend_q   <= 1'b0;
			end else begin
				if (pos_q != OFF_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				if (hit) begin
					resume_q <= pos_q + 1'b1;
				end
				if (rel) begin
					cnt_q <= cnt1;
				end
				pend_q <= acc_new;
			end
		end
	end

	// offset of the hit waiting on its following byte
	always_ff @(posedge clk) begin
		if (accept && acc_new) begin
			pend_off_q <= start;
		end
	end

	bss_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.entry0    (entry0),
		.entry1    (entry1),
		.pop       (hits.valid && hits.ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign scan.ready        = room2;
	assign hits.valid        = not_empty;
	assign hits.match_offset = head.match_offset;
	assign hits.match_number = head.match_number;
	assign hits.last         = head.last;

`ifndef SYNTHESIS
	// a region end leaves no pending hit and restarts the position
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scan.region_end) |=> (!pend_q && pos_q == '0 && cnt_q == '0))
		else $error("region state not cleared after region end");

	// the skip point never runs ahead of the position
	a_resume_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		resume_q <= pos_q)
		else $error("resume point beyond byte position");

	// a pending hit is always resolved by the next accepted byte
	a_pend_resolved: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pend_q && !acc_new) |=> !pend_q)
		else $error("pending hit not resolved");

	// every reported hit carries a nonzero count
	a_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		hits.valid |-> (hits.match_number != '0))
		else $error("result with zero match number");
`endif

endmodule

>>> test/bounded_string_scanner_tb.sv
`timescale 1ns / 100ps
// bounded_string_scanner_tb: self-checking bench for the pattern scanner, with directed
// boundary cases, back-pressure and random pattern phases checked against a local predictor
// depends on bss_pkg, bss_ifs and the bounded_string_scanner rtl
module bounded_string_scanner_tb;
	import bss_pkg::*;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 420;
	localparam int REPORT_MAX     = 10;
	localparam longint unsigned POS_TOP = (64'd1 << OFFSET_BITS) - 64'd1;

	typedef logic [7:0] byte_q_t [$];
	typedef enum int {PAT_TEXT, PAT_WIDE, PAT_RAW, PAT_ONES, PAT_ZERO} pat_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bss_in_if  scan_ch ();
	bss_out_if hit_ch ();

	bounded_string_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan      (scan_ch),
		.hits      (hit_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// traffic shaping shared by sender, receiver and tests
	bit src_idle    = 1'b1;
	bit sink_idle   = 1'b1;
	bit hold_req    = 1'b0;
	bit region_open = 1'b0;
	int bytes_sent  = 0;
	int mismatches  = 0;

	// predictor configuration copy
	logic [8*PAT_BYTES-1:0] pat_m;
	logic [PLEN_W-1:0]      len_m;
	bit                     exact_m;

	// predictor region state
	logic [7:0]       win [0:MAX_PATTERN];
	longint unsigned  pos_m;
	longint unsigned  resume_m;
	logic [CNT_W-1:0] hits_in_region;
	bit               held_valid;
	longint unsigned  held_off;

	result_t hits_due [$];

	function automatic logic visible(input logic [7:0] c);
		return (c >= 8'd32) && (c <= 8'd126);
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

	function automatic void clear_region();
		for (int i = 0; i <= MAX_PATTERN; i++) win[i] = 8'h00;
		pos_m = 0;
		resume_m = 0;
		hits_in_region = '0;
		held_valid = 1'b0;
		held_off = 0;
	endfunction

	// counts an accepted hit, saturating
	function automatic result_t record_hit(input longint unsigned off);
		result_t r;
		if (hits_in_region != '1) hits_in_region++;
		r.match_offset = off[OFF_W-1:0];
		r.match_number = hits_in_region;
		r.last = 1'b0;
		return r;
	endfunction

	// advance the predictor by one scanned byte and queue the hits it reports
	function automatic void search_step(input logic [7:0] b, input logic fin);
		result_t         found [2];
		int              n;
		int              plen;
		longint unsigned p;
		longint unsigned start;
		bit              same;
		logic [7:0]      d;
		logic [7:0]      q;
		n = 0;
		p = pos_m;
		plen = (int'(len_m) > MAX_PATTERN) ? MAX_PATTERN : int'(len_m);

		// this byte is the trailing boundary of a waiting hit
		if (held_valid) begin
			held_valid = 1'b0;
			if (!visible(b)) begin
				found[n] = record_hit(held_off);
				n++;
			end
		end

		for (int i = MAX_PATTERN; i > 0; i--) win[i] = win[i-1];
		win[0] = b;

		// candidate ending on this byte
		if (plen > 0 && p < POS_TOP && p + 1 >= plen) begin
			start = p + 1 - plen;
			if (start >= resume_m) begin
				same = 1'b1;
				for (int i = 0; i < plen; i++) begin
					d = win[plen-1-i];
					q = (i < PAT_BYTES) ? pat_m[8*i +: 8] : 8'h00;
					if (exact_m ? (d != q) : (upcase(d) != upcase(q))) same = 1'b0;
				end
				if (same) begin
					resume_m = start + plen;
					if (start == 0 || !visible(win[plen])) begin
						if (fin) begin
							found[n] = record_hit(start);
							n++;
						end else begin
							held_valid = 1'b1;
							held_off = start;
						end
					end
				end
			end
		end

		if (pos_m < POS_TOP) pos_m++;
		if (n > 0) found[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) hits_due = {hits_due, found[i]};
		if (fin) clear_region();
	endfunction

	function automatic void report(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("[%0t] %s: expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
		end
	endfunction

	// monitor: check results, then feed accepted requests to the predictor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (hit_ch.valid && hit_ch.ready) begin
				if (hits_due.size() == 0) begin
					report("result with none due, offset", 64'd0, hit_ch.match_offset);
				end else begin
					want = hits_due.pop_front();
					if (hit_ch.match_offset !== want.match_offset)
						report("match_offset", want.match_offset, hit_ch.match_offset);
					if (hit_ch.match_number !== want.match_number)
						report("match_number", want.match_number, hit_ch.match_number);
					if (hit_ch.last !== want.last)
						report("last", want.last, hit_ch.last);
				end
			end
			if (scan_ch.valid && scan_ch.ready) begin
				search_step(scan_ch.data_byte, scan_ch.region_end);
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((scan_ch.valid && scan_ch.ready) || (hit_ch.valid && hit_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bounded_string_scanner verification failed");
		$finish;
	end

	// result receiver: random stall per result, long hold-off on request
	initial begin : result_sink
		int stall;
		hit_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hit_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = sink_idle ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				hit_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			hit_ch.ready = 1'b1;
			do @(posedge clk); while (!hit_ch.valid && !hold_req);
			@(negedge clk);
		end
	end

	// offer one byte, after a random gap while src_idle is set, and wait for the request to be taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = src_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			scan_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_ch.valid = 1'b1;
		scan_ch.data_byte = b;
		scan_ch.region_end = fin;
		do @(posedge clk); while (!scan_ch.ready);
		@(negedge clk);
		region_open = !fin;
		bytes_sent++;
	endtask

	task automatic send_region(input byte_q_t r);
		for (int i = 0; i < r.size(); i++) send_byte(r[i], i == r.size() - 1);
	endtask

	// stop offering, let every due result arrive and the block go quiet
	task automatic settle();
		scan_ch.valid = 1'b0;
		while (hits_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (r)
			REG_PATTERN_LOW:    pat_m[CFG_W-1:0] = v;
			REG_PATTERN_HIGH:   pat_m[2*CFG_W-1:CFG_W] = v;
			REG_PATTERN_LENGTH: len_m = v[PLEN_W-1:0];
			REG_EXACT_MODE:     exact_m = v[0];
			default: ;
		endcase
	endtask

	task automatic load_pattern(input logic [127:0] bits, input int len, input bit exact);
		logic [CFG_W-1:0] v;
		settle();
		set_reg(REG_PATTERN_LOW, bits[63:0]);
		set_reg(REG_PATTERN_HIGH, bits[127:64]);
		// unused upper bits of the short registers carry noise
		v = {$urandom, $urandom};
		v[PLEN_W-1:0] = len[PLEN_W-1:0];
		set_reg(REG_PATTERN_LENGTH, v);
		v = {$urandom, $urandom};
		v[0] = exact;
		set_reg(REG_EXACT_MODE, v);
	endtask

	function automatic logic [127:0] make_pattern(input pat_kind_t kind);
		logic [127:0] p;
		for (int i = 0; i < PAT_BYTES; i++) begin
			case (kind)
				PAT_TEXT: p[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(32, 126)) :
					$urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
				PAT_WIDE: p[8*i +: 8] = (i % 2 == 1) ? 8'h00 : 8'($urandom_range(32, 126));
				PAT_RAW:  p[8*i +: 8] = 8'($urandom_range(0, 255));
				PAT_ONES: p[8*i +: 8] = 8'hff;
				default:  p[8*i +: 8] = 8'h00;
			endcase
		end
		return p;
	endfunction

	// region of pattern copies (some with flipped case, some broken) among separators and noise
	function automatic byte_q_t build_region(input int segs);
		byte_q_t    r;
		int         plen;
		int         pick;
		int         cut;
		logic [7:0] c;
		plen = (int'(len_m) > MAX_PATTERN) ? MAX_PATTERN : int'(len_m);
		repeat (segs) begin
			pick = $urandom_range(0, 9);
			if (pick <= 4 && plen > 0) begin
				cut = plen;
				if (pick == 4 && plen > 1 && $urandom_range(0, 1)) cut = plen - 1;
				for (int k = 0; k < cut; k++) begin
					c = pat_m[8*k +: 8];
					if (!exact_m && ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
							&& $urandom_range(0, 1))
						c ^= 8'h20;
					r = {r, c};
				end
				// broken copy: one byte disturbed
				if (pick == 4 && cut == plen)
					r[r.size() - 1 - $urandom_range(0, plen - 1)] ^= 8'($urandom_range(1, 255));
			end else if (pick <= 6) begin
				r = {r, ($urandom_range(0, 1) ? 8'($urandom_range(0, 31)) :
					8'($urandom_range(127, 255)))};
			end else if (pick == 7) begin
				r = {r, 8'($urandom_range(32, 126))};
			end else begin
				repeat ($urandom_range(1, 4)) r = {r, 8'($urandom_range(0, 255))};
			end
		end
		return r;
	endfunction

	// one configuration, then mostly well-formed regions and some raw noise
	task automatic run_phase(input int len, input bit exact, input pat_kind_t kind,
			input int budget);
		int first;
		load_pattern(make_pattern(kind), len, exact);
		src_idle = $urandom_range(0, 3) != 0;
		sink_idle = $urandom_range(0, 3) != 0;
		first = bytes_sent;
		while (bytes_sent - first < budget) begin
			if ($urandom_range(0, 4) != 0) begin
				send_region(build_region($urandom_range(1, 8)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end
		if (region_open) send_byte(8'h00, 1'b1);
	endtask

	// letters match regardless of case; hit at region start needs no leading check
	task automatic test_case_fold();
		load_pattern(128'h6241, 2, 1'b0);
		send_region('{8'h61, 8'h42, 8'h00, 8'hff, 8'h41, 8'h62});
	endtask

	// exact compare rejects a case difference
	task automatic test_exact_compare();
		load_pattern(128'h6241, 2, 1'b1);
		send_region('{8'h61, 8'h62, 8'h00, 8'h41, 8'h62});
	endtask

	// one byte releases a waiting hit and completes a new one at region end
	task automatic test_two_results();
		load_pattern(128'h01, 1, 1'b1);
		send_region('{8'h01, 8'h01});
	endtask

	// printable trailing byte rejects a hit; 127 counts as a boundary
	task automatic test_boundaries();
		load_pattern(128'h746163, 3, 1'b0);
		send_region('{8'h63, 8'h61, 8'h74, 8'h7e, 8'h7f, 8'h43, 8'h41, 8'h54});
	endtask

	// rejected hit (printable leading byte) still skips overlapping candidates
	task automatic test_skip_after_hit();
		load_pattern(128'h6161, 2, 1'b0);
		send_region('{8'h62, 8'h61, 8'h61, 8'h61, 8'h1f});
	endtask

	// zero pattern length never matches
	task automatic test_zero_length();
		load_pattern(128'h41, 0, 1'b0);
		send_region('{8'h41, 8'h00});
	endtask

	// receiver holds off while the sender keeps offering a hit on every byte
	task automatic test_backpressure();
		byte_q_t r;
		load_pattern(128'h01, 1, 1'b1);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		hold_req = 1'b1;
		repeat (40) r = {r, 8'h01};
		send_region(r);
		// sender waits here until every result has drained
		settle();
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_random_phases();
		int first;
		first = bytes_sent;
		// extreme settings first
		run_phase(1, 1'b0, PAT_TEXT, 40);
		run_phase(16, 1'b0, PAT_TEXT, 40);
		run_phase(16, 1'b1, PAT_ONES, 30);
		run_phase(0, 1'b1, PAT_ZERO, 20);
		run_phase(31, 1'b1, PAT_RAW, 40);
		run_phase(17, 1'b0, PAT_TEXT, 40);
		run_phase(6, 1'b1, PAT_WIDE, 40);
		run_phase(4, 1'b1, PAT_ZERO, 30);
		while (bytes_sent - first < RANDOM_ITEMS) begin
			run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8),
				$urandom_range(0, 1), pat_kind_t'($urandom_range(0, 4)), 40);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PATTERN_LOW;
		cfg_data = '0;
		scan_ch.valid = 1'b0;
		scan_ch.data_byte = 8'h00;
		scan_ch.region_end = 1'b0;
		pat_m = '0;
		len_m = PLEN_W'(1);
		exact_m = 1'b0;
		clear_region();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_case_fold();
		test_exact_compare();
		test_two_results();
		test_boundaries();
		test_skip_after_hit();
		test_zero_length();
		test_backpressure();
		test_random_phases();

		settle();
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("bounded_string_scanner verification clean");
		end else begin
			$display("bounded_string_scanner verification failed");
		end
		$finish;
	end

endmodule
